>>> rtl/core/tcd_pkg.sv
// Shared types and constants of the two-way cache tag directory.
// Used by the controller, the datapath and the top level; depends on nothing.
package tcd_pkg;

  localparam int DEF_SET_COUNT    = 16;
  localparam int DEF_OFFSET_BITS  = 3;
  localparam int DEF_ADDRESS_BITS = 24;

  localparam int COUNT_BITS = 32;

  // Result word: hit, way, hit_total, miss_total from bit 0 up, zero padded to bytes.
  localparam int OUT_USED_BITS = 2 + 2 * COUNT_BITS;
  localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS  = OUT_DATA_BITS - OUT_USED_BITS;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;   // write one cleared set during the clearing pass
    logic lookup;  // read both ways and the LRU bit of the requested set
    logic update;  // refill or touch the set, count, and load the result
  } tcd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // the clearing pass is at its final set
    logic out_free;    // the result register can take a new result
  } tcd_stat_t;

endpackage

>>> rtl/core/tcd_ctrl.sv
// Controller of the two-way cache tag directory: clearing pass, request
// acceptance and update sequencing. Depends on tcd_pkg.
module tcd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  tcd_pkg::tcd_stat_t stat,
  output tcd_pkg::tcd_cmd_t  cmd
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.lookup = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // The set data is registered now; wait only for room in the result register.
        if (stat.out_free) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

>>> rtl/core/tcd_datapath.sv
// Datapath of the two-way cache tag directory: tag/valid and LRU memories,
// tag compare, way choice, hit and miss counters and the result register.
// Depends on tcd_pkg.
module tcd_datapath #(
  parameter int SET_COUNT    = tcd_pkg::DEF_SET_COUNT,
  parameter int OFFSET_BITS  = tcd_pkg::DEF_OFFSET_BITS,
  parameter int ADDRESS_BITS = tcd_pkg::DEF_ADDRESS_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ADDRESS_BITS-1:0]       address,
  input  tcd_pkg::tcd_cmd_t             cmd,
  output tcd_pkg::tcd_stat_t            stat,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tcd_pkg::OUT_DATA_BITS-1:0] m_tdata
);

  localparam int INDEX_BITS = $clog2(SET_COUNT);
  localparam int TAG_BITS   = ADDRESS_BITS - OFFSET_BITS - INDEX_BITS;
  localparam int WORD_BITS  = TAG_BITS + 1;

  // Each way word holds the tag above a valid bit.
  logic [WORD_BITS-1:0] way0_mem [SET_COUNT];
  logic [WORD_BITS-1:0] way1_mem [SET_COUNT];
  logic                 lru_mem  [SET_COUNT];

  logic [INDEX_BITS-1:0] clr_idx;
  logic [INDEX_BITS-1:0] set_in;
  logic [TAG_BITS-1:0]   tag_in;

  logic [INDEX_BITS-1:0] set_q;
  logic [TAG_BITS-1:0]   tag_q;
  logic [WORD_BITS-1:0]  rd0;
  logic [WORD_BITS-1:0]  rd1;
  logic                  rd_lru;

  logic hit0;
  logic hit1;
  logic hit;
  logic way;

  logic [INDEX_BITS-1:0] wr_idx;
  logic [WORD_BITS-1:0]  wr_word;
  logic                  we0;
  logic                  we1;
  logic                  we_lru;
  logic                  wr_lru;

  logic [tcd_pkg::COUNT_BITS-1:0] hit_cnt;
  logic [tcd_pkg::COUNT_BITS-1:0] miss_cnt;
  logic                           hit_q;
  logic                           way_q;

  assign set_in = address[OFFSET_BITS +: INDEX_BITS];
  assign tag_in = address[ADDRESS_BITS-1 -: TAG_BITS];

  assign hit0 = rd0[0] && (rd0[WORD_BITS-1:1] == tag_q);
  assign hit1 = rd1[0] && (rd1[WORD_BITS-1:1] == tag_q);
  assign hit  = hit0 || hit1;

  always_comb begin
    if (hit0) begin
      way = 1'b0;
    end else if (hit1) begin
      way = 1'b1;
    end else if (!rd0[0]) begin
      way = 1'b0;
    end else if (!rd1[0]) begin
      way = 1'b1;
    end else begin
      way = rd_lru;
    end
  end

  // One write port per memory, shared by the clearing pass and the update.
  always_comb begin
    if (cmd.clear) begin
      wr_idx  = clr_idx;
      wr_word = '0;
      wr_lru  = 1'b0;
      we0     = 1'b1;
      we1     = 1'b1;
      we_lru  = 1'b1;
    end else begin
      wr_idx  = set_q;
      wr_word = {tag_q, 1'b1};
      wr_lru  = ~way;
      we0     = cmd.update && !hit && !way;
      we1     = cmd.update && !hit && way;
      we_lru  = cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (we0) begin
      way0_mem[wr_idx] <= wr_word;
    end
    if (we1) begin
      way1_mem[wr_idx] <= wr_word;
    end
    if (we_lru) begin
      lru_mem[wr_idx] <= wr_lru;
    end
    if (cmd.lookup) begin
      rd0    <= way0_mem[set_in];
      rd1    <= way1_mem[set_in];
      rd_lru <= lru_mem[set_in];
      set_q  <= set_in;
      tag_q  <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  assign stat.clear_last = (clr_idx == INDEX_BITS'(SET_COUNT - 1));
  assign stat.out_free   = !m_tvalid || m_tready;

  // The counters only move on an update, which waits for a free result
  // register, so they can feed the result word directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt  <= '0;
      miss_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.update) begin
        if (hit) begin
          hit_cnt <= hit_cnt + 1'b1;
        end else begin
          miss_cnt <= miss_cnt + 1'b1;
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit_q <= hit;
      way_q <= way;
    end
  end

  assign m_tdata = {{tcd_pkg::OUT_PAD_BITS{1'b0}}, miss_cnt, hit_cnt, way_q, hit_q};

endmodule

>>> rtl/core/two_way_cache_tag_directory.sv
// Top level of the two-way set-associative cache tag directory with LRU
// replacement. Depends on tcd_pkg, tcd_ctrl and tcd_datapath.
//
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) takes one access address
//   per request. The master channel (m_tvalid, m_tready, m_tdata) returns one
//   result per request: hit flag, way, and the running hit and miss totals.
//   After a request is accepted, its set's memories are read into the lookup
//   registers; the update then loads the result into the output register.
//   Each request reads the set's tag, valid and LRU memories, then an update
//   writes them back, and the next request is taken only after that write.
//   Reset: the controller runs a clearing pass over SET_COUNT sets that zeroes
//   every valid bit and LRU bit; s_tready stays low until it completes. The
//   hit and miss counters and the result register clear at once.
//   Stall: a result waits in the output register while m_tready is low. A new
//   request is still accepted and looked up, then waits in the lookup state
//   until the waiting result is taken.
module two_way_cache_tag_directory #(
  parameter int SET_COUNT    = tcd_pkg::DEF_SET_COUNT,
  parameter int OFFSET_BITS  = tcd_pkg::DEF_OFFSET_BITS,
  parameter int ADDRESS_BITS = tcd_pkg::DEF_ADDRESS_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // access_address from bit 0 up, zero padded to whole bytes
  input  logic [((ADDRESS_BITS+7)/8)*8-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // hit [0], way [1], hit_total [33:2], miss_total [65:34], zero padding above
  output logic [tcd_pkg::OUT_DATA_BITS-1:0]   m_tdata
);

  tcd_pkg::tcd_cmd_t  cmd;
  tcd_pkg::tcd_stat_t stat;

  tcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcd_datapath #(
    .SET_COUNT    (SET_COUNT),
    .OFFSET_BITS  (OFFSET_BITS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .address  (s_tdata[ADDRESS_BITS-1:0]),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

>>> rtl/core/tcd_checker.sv
// Port-level checks of the two-way cache tag directory, bound to its top
// level. Depends on tcd_pkg and two_way_cache_tag_directory.
module tcd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [tcd_pkg::OUT_DATA_BITS-1:0] m_tdata
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Only one request is in flight: none is taken in the cycle after an accept.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted during lookup");

  // With room in the output register when the lookup ends, a request yields its result.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 (!m_tvalid || m_tready) |=> m_tvalid)
    else $error("result missing after lookup");

  // Every result has counted its own request, so its hit and miss totals are not both zero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[33:2] != 32'd0) || (m_tdata[65:34] != 32'd0))
    else $error("result with both totals zero");

  // Reset starts the clearing pass with no request taken and no result shown.
  assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("block active right after reset");

endmodule

bind two_way_cache_tag_directory tcd_checker u_tcd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
